>>> src/cee_pkg.sv
// Shared beat types, mode codes and character helpers for the escape encoder.
`default_nettype none

package cee_pkg;

   // Encoding mode codes carried in the request cmd field.
   localparam logic [2:0] MODE_TRUSTED = 3'd0;
   localparam logic [2:0] MODE_HTML    = 3'd1;
   localparam logic [2:0] MODE_ATTR    = 3'd2;
   localparam logic [2:0] MODE_PERCENT = 3'd3;
   localparam logic [2:0] MODE_JS      = 3'd4;

   // Longest escape sequence, in bytes, and the width of a byte index.
   localparam int unsigned SEQ_MAX = 6;
   localparam int unsigned IDX_W   = 3;

   // Low nibble mask for hex digit extraction.
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;

   // Request beat: one source byte and its mode.
   typedef struct packed {
      logic [7:0] in_byte;
      logic [2:0] cmd;
   } req_type;

   // Response beat: one encoded byte, last marks the end of the run.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // Encoder result for the byte index being presented.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       empty;
   } enc_type;

   // Uppercase hex digit for a nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] digit;
      if (nib < 4'd10) begin
         digit = 8'h30 + {4'd0, nib};
      end else begin
         digit = 8'h37 + {4'd0, nib};
      end
      return digit;
   endfunction

   // URL unreserved set: ASCII letters, digits and - _ . ~
   function automatic logic is_unreserved(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
             (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h5F ||
             b == 8'h2E || b == 8'h7E;
   endfunction

endpackage

`default_nettype wire

>>> src/cee_encode.sv
// Combinational escape table: byte at a given index of one byte's encoding.
`default_nettype none

module cee_encode (
   input  wire logic [7:0]                  in_byte,
   input  wire logic [2:0]                  cmd,
   input  wire logic [cee_pkg::IDX_W-1:0]   idx,
   output cee_pkg::enc_type                 enc
);

   logic [7:0]                seq [cee_pkg::SEQ_MAX];
   logic [cee_pkg::IDX_W-1:0] len;

   // Build the full escape sequence and its length for this byte and mode.
   always_comb begin
      for (int k = 0; k < cee_pkg::SEQ_MAX; k++) begin
         seq[k] = 8'h00;
      end
      seq[0] = in_byte;
      len    = cee_pkg::IDX_W'(1);
      case (cmd) inside
         cee_pkg::MODE_TRUSTED: begin
            len = cee_pkg::IDX_W'(1);
         end
         cee_pkg::MODE_HTML, cee_pkg::MODE_ATTR: begin
            if (in_byte == "<") begin
               seq[0] = "&"; seq[1] = "l"; seq[2] = "t"; seq[3] = ";";
               len = cee_pkg::IDX_W'(4);
            end else if (in_byte == ">") begin
               seq[0] = "&"; seq[1] = "g"; seq[2] = "t"; seq[3] = ";";
               len = cee_pkg::IDX_W'(4);
            end else if (in_byte == "&") begin
               seq[0] = "&"; seq[1] = "a"; seq[2] = "m"; seq[3] = "p"; seq[4] = ";";
               len = cee_pkg::IDX_W'(5);
            end else if (cmd == cee_pkg::MODE_ATTR && in_byte == 8'h22) begin
               seq[0] = "&"; seq[1] = "q"; seq[2] = "u"; seq[3] = "o";
               seq[4] = "t"; seq[5] = ";";
               len = cee_pkg::IDX_W'(6);
            end else if (cmd == cee_pkg::MODE_ATTR && in_byte == 8'h27) begin
               seq[0] = "&"; seq[1] = "#"; seq[2] = "3"; seq[3] = "9"; seq[4] = ";";
               len = cee_pkg::IDX_W'(5);
            end
         end
         cee_pkg::MODE_PERCENT: begin
            if (cee_pkg::is_unreserved(in_byte)) begin
               len = cee_pkg::IDX_W'(1);
            end else if (in_byte == " ") begin
               seq[0] = "+";
               len = cee_pkg::IDX_W'(1);
            end else begin
               seq[0] = "%";
               seq[1] = cee_pkg::hex_digit(in_byte[7:4]);
               seq[2] = cee_pkg::hex_digit(4'(in_byte & cee_pkg::NIBBLE_MASK));
               len = cee_pkg::IDX_W'(3);
            end
         end
         cee_pkg::MODE_JS: begin
            seq[0] = 8'h5C;
            if (in_byte == 8'h27 || in_byte == 8'h22 || in_byte == 8'h5C) begin
               seq[1] = in_byte;
               len = cee_pkg::IDX_W'(2);
            end else if (in_byte == 8'h0A) begin
               seq[1] = "n";
               len = cee_pkg::IDX_W'(2);
            end else if (in_byte == 8'h0D) begin
               seq[1] = "r";
               len = cee_pkg::IDX_W'(2);
            end else if (in_byte == 8'h09) begin
               seq[1] = "t";
               len = cee_pkg::IDX_W'(2);
            end else if (in_byte == "<" || in_byte == ">" || in_byte == "&") begin
               seq[1] = "u"; seq[2] = "0"; seq[3] = "0";
               seq[4] = (in_byte == "&") ? "2" : "3";
               seq[5] = (in_byte == "<") ? "C" : (in_byte == ">") ? "E" : "6";
               len = cee_pkg::IDX_W'(6);
            end else begin
               seq[0] = in_byte;
               len = cee_pkg::IDX_W'(1);
            end
         end
         default: begin
            // Modes without meaning drop the byte entirely.
            len = '0;
         end
      endcase
   end

   // Select the byte at the current index and flag the end of the run.
   always_comb begin
      enc.data  = 8'h00;
      if (idx < cee_pkg::IDX_W'(cee_pkg::SEQ_MAX)) begin
         enc.data = seq[idx];
      end
      enc.empty = (len == '0);
      enc.last  = (idx == len - cee_pkg::IDX_W'(1));
   end

endmodule

`default_nettype wire

>>> src/context_escape_encoder.sv
// Top level of the context escape encoder: input stage, run sequencer, output register.
//
// Usage: each request beat carries one source byte and a mode. The block answers
// with a run of one to six response beats, the escaped form of the byte, with
// last set on the final beat of the run. Modes without meaning give no beats.
//
// An accepted request passes the input stage and then the output register.
// A byte that escapes to one output byte sustains one request per cycle while
// the receiver does not stall; one that escapes to N bytes holds the input stage
// until its last byte is emitted, since the single output register emits one
// byte per cycle when not stalled. An unknown mode frees the stage with no output.
//
// When the receiver stalls, the output register holds its beat and the input
// stage waits on it, so req_stall rises while a run is in flight. Reset empties
// both stages; no response beat is valid after reset.
`default_nettype none

module context_escape_encoder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire cee_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      cee_pkg::rsp_type rsp_data
);

   logic                      s1_valid_ff, s1_valid_in;
   cee_pkg::req_type          s1_data_ff, s1_data_in;
   logic [cee_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                      out_valid_ff, out_valid_in;
   cee_pkg::rsp_type          out_data_ff, out_data_in;

   cee_pkg::enc_type enc;
   logic             out_ready;
   logic             emit;
   logic             done;
   logic             req_take;

   cee_encode u_encode (
      .in_byte (s1_data_ff.in_byte),
      .cmd     (s1_data_ff.cmd),
      .idx     (idx_ff),
      .enc     (enc)
   );

   // Handshake decisions for the input stage and the output register.
   always_comb begin
      out_ready = !out_valid_ff || !rsp_stall;
      emit      = s1_valid_ff && !enc.empty && out_ready;
      done      = s1_valid_ff && (enc.empty || (out_ready && enc.last));
      req_stall = s1_valid_ff && !done;
      req_take  = req_valid && !req_stall;
   end

   // Input stage: load a new beat, step through its run, or drain.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      idx_in      = idx_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
         idx_in      = '0;
      end else if (done) begin
         s1_valid_in = 1'b0;
         idx_in      = '0;
      end else if (emit) begin
         idx_in = idx_ff + cee_pkg::IDX_W'(1);
      end
   end

   // Output register: takes an encoded byte whenever it is free or being read.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_ready) begin
         out_valid_in         = emit;
         out_data_in.out_byte = enc.data;
         out_data_in.last     = enc.last;
      end
   end

   // Control state is cleared by reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A run that is still in progress keeps the input side stalled.
   a_run_holds_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !enc.empty && !enc.last) |-> req_stall)
      else $error("input accepted while an escape run was unfinished");

   // The byte index never runs past the longest sequence.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (idx_ff < cee_pkg::IDX_W'(cee_pkg::SEQ_MAX)))
      else $error("byte index beyond the longest escape sequence");

   // The index only moves away from zero while a beat occupies the stage.
   a_idx_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> s1_valid_ff)
      else $error("byte index nonzero with the input stage empty");

   // The byte index only steps forward on a cycle that emitted a byte.
   a_step_emits: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && idx_ff != '0 && !$stable(idx_ff)) |-> $past(emit))
      else $error("byte index advanced without an emitted byte");

endmodule

`default_nettype wire
